FILE: rtl/mqls_pkg.sv
`default_nettype none

package mqls_pkg;

    // Weight format and sigmoid table shape
    localparam int WEIGHT_FRACTION_BITS  = 16;
    localparam int SIGMOID_TABLE_ENTRIES = 256;
    localparam int SIG_IDX_W             = $clog2(SIGMOID_TABLE_ENTRIES);
    localparam int SIG_SH                = WEIGHT_FRACTION_BITS + 4;
    localparam longint SIG_LIM           = longint'(8) << WEIGHT_FRACTION_BITS;
    localparam longint unsigned E_INV_Q32 = 64'd1580030169;

    // Shared multiplier widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 22;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_STATE = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_EXPLORE     = 3'd0;
    localparam logic [2:0] CFG_Q_BLEND     = 3'd1;
    localparam logic [2:0] CFG_NET_LEARN   = 3'd2;
    localparam logic [2:0] CFG_REWARD_S0A0 = 3'd3;
    localparam logic [2:0] CFG_REWARD_S0A1 = 3'd4;
    localparam logic [2:0] CFG_REWARD_S1A0 = 3'd5;
    localparam logic [2:0] CFG_REWARD_S1A1 = 3'd6;

    typedef logic [16:0] sig_tab_t [SIGMOID_TABLE_ENTRIES];

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_H_X,
        ST_SG_A,
        ST_SG_B,
        ST_SG_C,
        ST_O_INIT,
        ST_O_MUL,
        ST_O_ACC,
        ST_O_X,
        ST_DECIDE,
        ST_TGT_A,
        ST_TGT_B,
        ST_ERR,
        ST_GRAD,
        ST_DELTA,
        ST_ED,
        ST_ED_LATCH,
        ST_HO_MUL,
        ST_HO_UPD,
        ST_HO_BIAS,
        ST_IH_HH,
        ST_IH_T1,
        ST_IH_T,
        ST_IH_E,
        ST_IH_UPD,
        ST_FIN
    } state_t;

    // Unsigned 64-bit quotient by shift and subtract, used at elaboration only
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned dvs);
        logic [64:0]     rem;
        longint unsigned quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, dvs}) begin
                rem = rem - {1'b0, dvs};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Build the sigmoid points over [-8, +8] at elaboration
    function automatic sig_tab_t sig_build();
        sig_tab_t tab;
        longint unsigned span;
        longint unsigned mag;
        longint unsigned t;
        longint unsigned n;
        longint unsigned f;
        longint unsigned term;
        longint unsigned r;
        longint unsigned e;
        longint unsigned den;
        longint signed num;
        longint signed sum;
        span = 64'(SIGMOID_TABLE_ENTRIES - 1);
        for (int k = 0; k < SIGMOID_TABLE_ENTRIES; k++) begin
            num = 16 * longint'(k) - 8 * longint'(span);
            mag = (num < 0) ? 64'(-num) : 64'(num);
            t = udiv64(mag << 32, span);
            n = t >> 32;
            f = t & 64'hFFFF_FFFF;
            term = 64'd1 << 32;
            sum = longint'(64'd1 << 32);
            for (int kk = 1; kk <= 24; kk++) begin
                term = udiv64((term * f) >> 32, 64'(kk));
                if ((kk & 1) == 1) sum = sum - $signed(term);
                else sum = sum + $signed(term);
            end
            r = (sum < 0) ? 64'd0 : 64'(sum);
            for (longint unsigned m = 0; m < n && m < 64; m++) begin
                r = (r * E_INV_Q32) >> 32;
            end
            e = r;
            den = (64'd1 << 32) + e;
            if (num >= 0) tab[k] = 17'(udiv64((64'd1 << 48) + (den >> 1), den));
            else tab[k] = 17'(udiv64((e << 16) + (den >> 1), den));
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TAB = sig_build();

    // Weight add with saturation to signed 32 bits
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] w,
                                                   input logic signed [47:0] d);
        logic signed [48:0] s;
        s = 49'(w) + 49'(d);
        if (s > 49'sd2147483647) return 32'sh7FFF_FFFF;
        if (s < -49'sd2147483648) return 32'sh8000_0000;
        return s[31:0];
    endfunction

    // Move a Q.16 value into the weight format
    function automatic logic signed [47:0] wf16(input logic signed [47:0] v);
        if (WEIGHT_FRACTION_BITS >= 16) return v <<< (WEIGHT_FRACTION_BITS - 16);
        return (v + (48'sd1 <<< (15 - WEIGHT_FRACTION_BITS))) >>>
               (16 - WEIGHT_FRACTION_BITS);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mlp_q_learning_step_top.sv
// Load weight, set state and idle opcodes give their result word in the cycle after accept.
// A learning step sends every forward, sigmoid and update product through one shared
// 34x22 multiplier.
// Throughput: one step at a time; s_tready is low while a step runs.
// Reset (aresetn low, synchronous): weights zero, state 0, config registers to defaults.
`default_nettype none

module mlp_q_learning_step_top #(
    parameter int HIDDEN_SIZE = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // opcode[1:0], weight_index[5:2], weight_value[37:6], new_state[38],
    // explore_draw[54:39], random_action[55]
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // chosen_action[0], explored[1], q_value_a0[18:2], q_value_a1[35:19],
    // reward_given[51:36], zero[55:52]
    output logic [55:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [19:0] cfg_data
);

    localparam int CW  = $clog2(HIDDEN_SIZE + 1);
    localparam int HW  = (HIDDEN_SIZE > 1) ? $clog2(HIDDEN_SIZE) : 1;
    localparam int PW  = mqls_pkg::PROD_W;
    localparam int AW  = mqls_pkg::MUL_A_W;
    localparam int BW  = mqls_pkg::MUL_B_W;
    localparam int ACW = PW + 4;
    localparam int XW  = 44;
    localparam int SE  = mqls_pkg::SIGMOID_TABLE_ENTRIES;
    localparam int IW  = mqls_pkg::SIG_IDX_W;
    localparam logic signed [XW-1:0]  X_LIM    = XW'(mqls_pkg::SIG_LIM);
    localparam logic signed [ACW-1:0] ACC_HALF = ACW'(64'd1 << 15);
    localparam logic [16:0]           ONE_Q16  = 17'h10000;

    // Input word fields
    logic [1:0]         s_opcode;
    logic [3:0]         s_weight_index;
    logic signed [31:0] s_weight_value;
    logic               s_new_state;
    logic [15:0]        s_explore_draw;
    logic               s_random_action;

    assign s_opcode        = s_tdata[1:0];
    assign s_weight_index  = s_tdata[5:2];
    assign s_weight_value  = s_tdata[37:6];
    assign s_new_state     = s_tdata[38];
    assign s_explore_draw  = s_tdata[54:39];
    assign s_random_action = s_tdata[55];

    // Control state
    mqls_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg;
    logic             ocnt_reg;
    logic             kind_out_reg;
    logic             cur_state_reg;
    logic             m_tvalid_reg;
    logic [55:0]      m_tdata_reg;

    // Configuration
    logic [15:0] thr_reg;
    logic [15:0] qa_reg;
    logic [19:0] eta_reg;
    logic [15:0] rwd_reg [4];

    // Network weights: rows input 0, input 1, bias; hidden rows then bias row
    logic signed [31:0] wih_reg [3][HIDDEN_SIZE];
    logic signed [31:0] who_reg [HIDDEN_SIZE+1][2];

    // Step payload
    logic [16:0]           hid_reg [HIDDEN_SIZE];
    logic [16:0]           y_reg [2];
    logic signed [XW-1:0]  x_reg;
    logic signed [ACW-1:0] acc_reg;
    logic [16:0]           lo_reg;
    logic [15:0]           draw_reg;
    logic                  ra_reg;
    logic                  act_reg;
    logic                  expl_reg;
    logic [15:0]           rewv_reg;
    logic signed [19:0]    err_reg;
    logic signed [19:0]    delta_reg;
    logic signed [23:0]    ed_reg;

    // Shared multiplier
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] rnd16;
    logic signed [PW-1:0] rnd_w;
    logic signed [PW-1:0] rnd_x;

    mqls_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod_reg),
        .rnd16    (rnd16),
        .rnd_w    (rnd_w),
        .rnd_x    (rnd_x)
    );

    // Helpers
    logic             s_acc;
    logic             out_free;
    logic             out_load;
    logic             last_hid;
    logic [HW-1:0]    cnt_h;
    logic [16:0]      yact;
    logic             explore_pick;
    logic             act_pick;
    logic signed [XW-1:0]  x_plus;
    logic signed [PW-1:0]  idx_full;
    logic [IW-1:0]         sig_idx;
    logic [IW-1:0]         sig_idx_hi;
    logic signed [17:0]    sig_diff;
    logic signed [PW-1:0]  interp;
    logic                  sig_done;
    logic [16:0]           sig_val;
    logic signed [ACW-1:0] acc_rnd;
    logic signed [ACW-1:0] tgt_rnd;
    logic signed [47:0]    et;
    mqls_pkg::state_t      sig_ret;

    assign out_free     = !m_tvalid_reg || m_tready;
    assign s_acc        = s_tvalid && s_tready;
    assign out_load     = (s_acc && s_opcode != mqls_pkg::OP_STEP) ||
                          (state_reg == mqls_pkg::ST_FIN && out_free);
    assign last_hid     = (cnt_reg == CW'(HIDDEN_SIZE - 1));
    assign cnt_h        = cnt_reg[HW-1:0];
    assign yact         = y_reg[act_reg];
    assign explore_pick = (draw_reg < thr_reg);
    assign act_pick     = explore_pick ? ra_reg : (y_reg[1] > y_reg[0]);
    assign x_plus       = x_reg + X_LIM;
    assign idx_full     = prod_reg >>> mqls_pkg::SIG_SH;
    assign sig_idx      = idx_full[IW-1:0];
    assign sig_idx_hi   = sig_idx + IW'(1);
    assign sig_diff     = $signed({1'b0, mqls_pkg::SIG_TAB[sig_idx_hi]}) -
                          $signed({1'b0, mqls_pkg::SIG_TAB[sig_idx]});
    assign interp       = prod_reg >>> mqls_pkg::SIG_SH;
    assign acc_rnd      = (acc_reg + ACC_HALF) >>> 16;
    assign tgt_rnd      = (acc_reg + ACW'(prod_reg) + ACC_HALF) >>> 16;
    assign et           = mqls_pkg::wf16(48'(rnd16));
    assign sig_ret      = !kind_out_reg ? (last_hid ? mqls_pkg::ST_O_INIT : mqls_pkg::ST_H_X)
                                        : (ocnt_reg ? mqls_pkg::ST_DECIDE : mqls_pkg::ST_O_INIT);

    // Sigmoid result: saturated ends or interpolated point
    always_comb begin
        sig_done = 1'b0;
        sig_val  = mqls_pkg::SIG_TAB[SE-1];
        case (state_reg)
            mqls_pkg::ST_SG_A: begin
                if (x_reg <= -X_LIM) begin
                    sig_done = 1'b1;
                    sig_val  = mqls_pkg::SIG_TAB[0];
                end else if (x_reg >= X_LIM) begin
                    sig_done = 1'b1;
                end
            end
            mqls_pkg::ST_SG_B: begin
                if (idx_full >= $signed(PW'(SE - 1))) sig_done = 1'b1;
            end
            mqls_pkg::ST_SG_C: begin
                sig_done = 1'b1;
                sig_val  = 17'(interp + $signed(PW'(lo_reg)));
            end
            default: ;
        endcase
    end

    // Multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            mqls_pkg::ST_SG_A: begin
                mul_a = x_plus[AW-1:0];
                mul_b = BW'(SE - 1);
            end
            mqls_pkg::ST_SG_B: begin
                mul_a = AW'(prod_reg[mqls_pkg::SIG_SH-1:0]);
                mul_b = BW'(sig_diff);
            end
            mqls_pkg::ST_O_MUL: begin
                mul_a = AW'(who_reg[cnt_reg][ocnt_reg]);
                mul_b = BW'(hid_reg[cnt_h]);
            end
            mqls_pkg::ST_TGT_A: begin
                mul_a = AW'(ONE_Q16 - {1'b0, qa_reg});
                mul_b = BW'(yact);
            end
            mqls_pkg::ST_TGT_B: begin
                mul_a = AW'(qa_reg);
                mul_b = BW'(rewv_reg);
            end
            mqls_pkg::ST_GRAD: begin
                mul_a = AW'(err_reg);
                mul_b = BW'(yact);
            end
            mqls_pkg::ST_DELTA: begin
                mul_a = rnd16[AW-1:0];
                mul_b = BW'(ONE_Q16 - yact);
            end
            mqls_pkg::ST_ED: begin
                mul_a = rnd16[AW-1:0];
                mul_b = BW'(eta_reg);
            end
            mqls_pkg::ST_HO_MUL: begin
                mul_a = AW'(ed_reg);
                mul_b = BW'(hid_reg[cnt_h]);
            end
            mqls_pkg::ST_IH_HH: begin
                mul_a = AW'(hid_reg[cnt_h]);
                mul_b = BW'(ONE_Q16 - hid_reg[cnt_h]);
            end
            mqls_pkg::ST_IH_T1: begin
                mul_a = AW'(who_reg[cnt_reg][act_reg]);
                mul_b = rnd16[BW-1:0];
            end
            mqls_pkg::ST_IH_T: begin
                mul_a = rnd_w[AW-1:0];
                mul_b = BW'(delta_reg);
            end
            mqls_pkg::ST_IH_E: begin
                mul_a = rnd16[AW-1:0];
                mul_b = BW'(eta_reg);
            end
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mqls_pkg::ST_IDLE:
                if (s_acc && s_opcode == mqls_pkg::OP_STEP) state_next = mqls_pkg::ST_H_X;
            mqls_pkg::ST_H_X:      state_next = mqls_pkg::ST_SG_A;
            mqls_pkg::ST_SG_A:     state_next = sig_done ? sig_ret : mqls_pkg::ST_SG_B;
            mqls_pkg::ST_SG_B:     state_next = sig_done ? sig_ret : mqls_pkg::ST_SG_C;
            mqls_pkg::ST_SG_C:     state_next = sig_ret;
            mqls_pkg::ST_O_INIT:   state_next = mqls_pkg::ST_O_MUL;
            mqls_pkg::ST_O_MUL:    state_next = mqls_pkg::ST_O_ACC;
            mqls_pkg::ST_O_ACC:
                state_next = last_hid ? mqls_pkg::ST_O_X : mqls_pkg::ST_O_MUL;
            mqls_pkg::ST_O_X:      state_next = mqls_pkg::ST_SG_A;
            mqls_pkg::ST_DECIDE:   state_next = mqls_pkg::ST_TGT_A;
            mqls_pkg::ST_TGT_A:    state_next = mqls_pkg::ST_TGT_B;
            mqls_pkg::ST_TGT_B:    state_next = mqls_pkg::ST_ERR;
            mqls_pkg::ST_ERR:      state_next = mqls_pkg::ST_GRAD;
            mqls_pkg::ST_GRAD:     state_next = mqls_pkg::ST_DELTA;
            mqls_pkg::ST_DELTA:    state_next = mqls_pkg::ST_ED;
            mqls_pkg::ST_ED:       state_next = mqls_pkg::ST_ED_LATCH;
            mqls_pkg::ST_ED_LATCH: state_next = mqls_pkg::ST_HO_MUL;
            mqls_pkg::ST_HO_MUL:   state_next = mqls_pkg::ST_HO_UPD;
            mqls_pkg::ST_HO_UPD:
                state_next = last_hid ? mqls_pkg::ST_HO_BIAS : mqls_pkg::ST_HO_MUL;
            mqls_pkg::ST_HO_BIAS:  state_next = mqls_pkg::ST_IH_HH;
            mqls_pkg::ST_IH_HH:    state_next = mqls_pkg::ST_IH_T1;
            mqls_pkg::ST_IH_T1:    state_next = mqls_pkg::ST_IH_T;
            mqls_pkg::ST_IH_T:     state_next = mqls_pkg::ST_IH_E;
            mqls_pkg::ST_IH_E:     state_next = mqls_pkg::ST_IH_UPD;
            mqls_pkg::ST_IH_UPD:
                state_next = last_hid ? mqls_pkg::ST_FIN : mqls_pkg::ST_IH_HH;
            mqls_pkg::ST_FIN:
                if (out_free) state_next = mqls_pkg::ST_IDLE;
            default:               state_next = mqls_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_tready = (state_reg == mqls_pkg::ST_IDLE) && out_free;
        m_tvalid = m_tvalid_reg;
        m_tdata  = m_tdata_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mqls_pkg::ST_IDLE;
            cnt_reg       <= '0;
            ocnt_reg      <= 1'b0;
            kind_out_reg  <= 1'b0;
            cur_state_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            // advance the unit counter
            if (s_acc) begin
                cnt_reg  <= '0;
                ocnt_reg <= 1'b0;
            end else if (sig_done && !kind_out_reg) begin
                if (!last_hid) cnt_reg <= cnt_reg + CW'(1);
            end else if (sig_done && kind_out_reg) begin
                ocnt_reg <= 1'b1;
            end else begin
                case (state_reg)
                    mqls_pkg::ST_O_INIT, mqls_pkg::ST_ED_LATCH, mqls_pkg::ST_HO_BIAS:
                        cnt_reg <= '0;
                    mqls_pkg::ST_O_ACC, mqls_pkg::ST_HO_UPD, mqls_pkg::ST_IH_UPD:
                        if (!last_hid) cnt_reg <= cnt_reg + CW'(1);
                    default: ;
                endcase
            end
            if (state_reg == mqls_pkg::ST_H_X) kind_out_reg <= 1'b0;
            if (state_reg == mqls_pkg::ST_O_X) kind_out_reg <= 1'b1;
            // current environment state
            if (s_acc && s_opcode == mqls_pkg::OP_STATE) cur_state_reg <= s_new_state;
            else if (state_reg == mqls_pkg::ST_FIN && out_free) cur_state_reg <= act_reg;
            // hold the result word until taken
            if (out_load) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= 16'd32768;
            qa_reg     <= 16'd6554;
            eta_reg    <= 20'd196608;
            rwd_reg[0] <= 16'd32768;
            rwd_reg[1] <= 16'd13107;
            rwd_reg[2] <= 16'd13107;
            rwd_reg[3] <= 16'd32768;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mqls_pkg::CFG_EXPLORE:   thr_reg <= cfg_data[15:0];
                mqls_pkg::CFG_Q_BLEND:   qa_reg  <= cfg_data[15:0];
                mqls_pkg::CFG_NET_LEARN: eta_reg <= cfg_data;
                mqls_pkg::CFG_REWARD_S0A0, mqls_pkg::CFG_REWARD_S0A1,
                mqls_pkg::CFG_REWARD_S1A0, mqls_pkg::CFG_REWARD_S1A1:
                    rwd_reg[2'(cfg_index - mqls_pkg::CFG_REWARD_S0A0)] <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Weight store: loads and backprop updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                for (int u = 0; u < HIDDEN_SIZE; u++) wih_reg[r][u] <= '0;
            end
            for (int r = 0; r <= HIDDEN_SIZE; r++) begin
                for (int c = 0; c < 2; c++) who_reg[r][c] <= '0;
            end
        end else begin
            if (s_acc && s_opcode == mqls_pkg::OP_LOAD) begin
                for (int r = 0; r < 3; r++) begin
                    for (int u = 0; u < HIDDEN_SIZE; u++) begin
                        if (int'(s_weight_index) == r * HIDDEN_SIZE + u)
                            wih_reg[r][u] <= s_weight_value;
                    end
                end
                for (int r = 0; r <= HIDDEN_SIZE; r++) begin
                    for (int c = 0; c < 2; c++) begin
                        if (int'(s_weight_index) == 3 * HIDDEN_SIZE + r * 2 + c)
                            who_reg[r][c] <= s_weight_value;
                    end
                end
            end
            case (state_reg)
                mqls_pkg::ST_HO_UPD:
                    who_reg[cnt_reg][act_reg] <=
                        mqls_pkg::sat_add(who_reg[cnt_reg][act_reg], 48'(rnd_x));
                mqls_pkg::ST_HO_BIAS:
                    who_reg[HIDDEN_SIZE][act_reg] <=
                        mqls_pkg::sat_add(who_reg[HIDDEN_SIZE][act_reg],
                                          mqls_pkg::wf16(-48'(ed_reg)));
                mqls_pkg::ST_IH_UPD: begin
                    wih_reg[{1'b0, cur_state_reg}][cnt_h] <=
                        mqls_pkg::sat_add(wih_reg[{1'b0, cur_state_reg}][cnt_h], et);
                    wih_reg[2][cnt_h] <= mqls_pkg::sat_add(wih_reg[2][cnt_h], -et);
                end
                default: ;
            endcase
        end
    end

    // Step datapath registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            draw_reg <= s_explore_draw;
            ra_reg   <= s_random_action;
        end
        if (sig_done) begin
            if (kind_out_reg) y_reg[ocnt_reg] <= sig_val;
            else hid_reg[cnt_h] <= sig_val;
        end
        case (state_reg)
            mqls_pkg::ST_H_X:
                x_reg <= XW'(wih_reg[{1'b0, cur_state_reg}][cnt_h]) - XW'(wih_reg[2][cnt_h]);
            mqls_pkg::ST_SG_B:     lo_reg <= mqls_pkg::SIG_TAB[sig_idx];
            mqls_pkg::ST_O_INIT:   acc_reg <= '0;
            mqls_pkg::ST_O_ACC:    acc_reg <= acc_reg + ACW'(prod_reg);
            mqls_pkg::ST_O_X:
                x_reg <= XW'(acc_rnd) - XW'(who_reg[HIDDEN_SIZE][ocnt_reg]);
            mqls_pkg::ST_DECIDE: begin
                expl_reg <= explore_pick;
                act_reg  <= act_pick;
                rewv_reg <= rwd_reg[{cur_state_reg, act_pick}];
            end
            mqls_pkg::ST_TGT_B:    acc_reg <= ACW'(prod_reg);
            mqls_pkg::ST_ERR:      err_reg <= 20'(tgt_rnd - ACW'(yact));
            mqls_pkg::ST_ED:       delta_reg <= 20'(rnd16);
            mqls_pkg::ST_ED_LATCH: ed_reg <= 24'(rnd16);
            default: ;
        endcase
        // load the result word
        if (out_load) begin
            if (state_reg == mqls_pkg::ST_FIN)
                m_tdata_reg <= {4'd0, rewv_reg, y_reg[1], y_reg[0], expl_reg, act_reg};
            else
                m_tdata_reg <= '0;
        end
    end

    // A step holds off further input words while it runs
    a_step_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_opcode == mqls_pkg::OP_STEP) |=> !s_tready)
        else $error("input accepted right after a learning step started");

    // The finished step moves the environment to the chosen action
    a_state_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mqls_pkg::ST_FIN && out_free) |=>
            (m_tvalid && cur_state_reg == m_tdata[0]))
        else $error("state does not follow the chosen action");

    // The unit counter stays within the hidden layer
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != mqls_pkg::ST_IDLE) |-> (cnt_reg <= CW'(HIDDEN_SIZE - 1)))
        else $error("hidden unit counter out of range");

endmodule

`default_nettype wire

FILE: rtl/mqls_mul.sv
`default_nettype none

module mqls_mul (
    input  wire logic                                   aclk,
    input  wire logic signed [mqls_pkg::MUL_A_W-1:0]    mul_a,
    input  wire logic signed [mqls_pkg::MUL_B_W-1:0]    mul_b,
    output logic signed [mqls_pkg::PROD_W-1:0]          prod_reg,
    output logic signed [mqls_pkg::PROD_W-1:0]          rnd16,
    output logic signed [mqls_pkg::PROD_W-1:0]          rnd_w,
    output logic signed [mqls_pkg::PROD_W-1:0]          rnd_x
);

    localparam int PW = mqls_pkg::PROD_W;
    localparam int WF = mqls_pkg::WEIGHT_FRACTION_BITS;
    localparam int XS = 32 - WF;
    localparam logic signed [PW-1:0] HALF16 = PW'(64'd1 << 15);
    localparam logic signed [PW-1:0] HALF_W = PW'(64'd1 << (WF - 1));
    localparam logic signed [PW-1:0] HALF_X = PW'(64'd1 << (XS - 1));

    // Register the product every cycle
    always_ff @(posedge aclk) begin
        prod_reg <= PW'(mul_a) * PW'(mul_b);
    end

    // Round half up at the shifts the sequencer needs
    assign rnd16 = (prod_reg + HALF16) >>> 16;
    assign rnd_w = (prod_reg + HALF_W) >>> WF;
    assign rnd_x = (prod_reg + HALF_X) >>> XS;

endmodule

`default_nettype wire

FILE: dv/tb_mlp_q_learning_step_top.sv
`default_nettype none

module tb_mlp_q_learning_step_top;

    // Opcode the block treats as a no-op
    localparam logic [1:0] OP_NOP = 2'd3;
    // Register slot past the end of the register list
    localparam logic [2:0] CFG_SPARE = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 60;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [19:0] cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;

    mlp_q_learning_step_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 aclk = ~aclk;

    // Track network state and hold the words the block owes us
    class qstep_scoreboard;
        logic [15:0] explore_thr;
        logic [15:0] blend_rate;
        logic [19:0] learn_rate;
        logic [15:0] reward_tab [4];
        int          env_state;
        int          w_in_hid [3][2];
        int          w_hid_out [3][2];
        longint      sig_points [256];
        logic [55:0] owed_words [$];
        int          errors;

        function new();
            build_points();
            explore_thr = 16'd32768;
            blend_rate = 16'd6554;
            learn_rate = 20'd196608;
            reward_tab = '{16'd32768, 16'd13107, 16'd13107, 16'd32768};
            env_state = 0;
            w_in_hid = '{default: 0};
            w_hid_out = '{default: 0};
            errors = 0;
        endfunction

        // Sigmoid points over [-8, +8] from a truncated series for e^-t
        function void build_points();
            longint unsigned mag, t, n, f, term, r, den;
            longint num, sum;
            for (int k = 0; k < 256; k++) begin
                num = 16 * longint'(k) - 8 * 255;
                mag = (num < 0) ? longint'(-num) : num;
                t = (mag << 32) / 255;
                n = t >> 32;
                f = t & 64'hFFFF_FFFF;
                term = 64'd1 << 32;
                sum = longint'(64'd1 << 32);
                for (int j = 1; j <= 24; j++) begin
                    term = ((term * f) >> 32) / longint'(j);
                    if (j % 2 == 1) sum = sum - longint'(term);
                    else sum = sum + longint'(term);
                end
                r = (sum < 0) ? 64'd0 : sum;
                for (longint unsigned m = 0; m < n; m++)
                    r = (r * mqls_pkg::E_INV_Q32) >> 32;
                den = (64'd1 << 32) + r;
                if (num >= 0) sig_points[k] = ((64'd1 << 48) + den / 2) / den;
                else sig_points[k] = ((r << 16) + den / 2) / den;
            end
        endfunction

        function longint round_sh(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function int sat_weight(int w, longint d);
            longint v;
            v = longint'(w) + d;
            if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return int'(v);
        endfunction

        function longint sigmoid(longint x);
            longint lim, lo, hi;
            longint unsigned scaled, idx, fr;
            lim = longint'(8) << 16;
            if (x <= -lim) return sig_points[0];
            if (x >= lim) return sig_points[255];
            scaled = longint'(x + lim) * 255;
            idx = scaled >> 20;
            fr = scaled & ((64'd1 << 20) - 1);
            if (idx >= 255) return sig_points[255];
            lo = sig_points[idx];
            hi = sig_points[idx + 1];
            return lo + (((hi - lo) * longint'(fr)) >>> 20);
        endfunction

        function void write_reg(logic [2:0] idx, logic [19:0] v);
            case (idx)
                mqls_pkg::CFG_EXPLORE:     explore_thr = v[15:0];
                mqls_pkg::CFG_Q_BLEND:     blend_rate = v[15:0];
                mqls_pkg::CFG_NET_LEARN:   learn_rate = v;
                mqls_pkg::CFG_REWARD_S0A0: reward_tab[0] = v[15:0];
                mqls_pkg::CFG_REWARD_S0A1: reward_tab[1] = v[15:0];
                mqls_pkg::CFG_REWARD_S1A0: reward_tab[2] = v[15:0];
                mqls_pkg::CFG_REWARD_S1A1: reward_tab[3] = v[15:0];
                default: ;
            endcase
        endfunction

        // Apply one accepted word and queue the result it owes
        function void note_word(logic [55:0] d);
            logic [1:0]  op;
            logic [3:0]  widx;
            int          s, act, expl;
            longint      hid [2], y [2];
            longint      acc, a, eta, rew, tgt, err, g, delta, ed, hh, t1, tt, et;
            op = d[1:0];
            widx = d[5:2];
            if (op == mqls_pkg::OP_LOAD) begin
                if (widx < 6) w_in_hid[widx / 2][widx % 2] = d[37:6];
                else if (widx < 12) w_hid_out[(widx - 6) / 2][(widx - 6) % 2] = d[37:6];
                owed_words.push_back('0);
                return;
            end
            if (op == mqls_pkg::OP_STATE) env_state = d[38];
            if (op != mqls_pkg::OP_STEP) begin
                owed_words.push_back('0);
                return;
            end
            // Forward pass
            s = env_state;
            for (int i = 0; i < 2; i++)
                hid[i] = sigmoid(longint'(w_in_hid[s][i]) - longint'(w_in_hid[2][i]));
            for (int o = 0; o < 2; o++) begin
                acc = 0;
                for (int j = 0; j < 2; j++) acc += longint'(w_hid_out[j][o]) * hid[j];
                y[o] = sigmoid(round_sh(acc, 16) - longint'(w_hid_out[2][o]));
            end
            // Pick the action
            if (d[54:39] < explore_thr) begin
                expl = 1;
                act = d[55];
            end else begin
                expl = 0;
                act = (y[1] > y[0]) ? 1 : 0;
            end
            rew = reward_tab[s * 2 + act];
            a = blend_rate;
            eta = learn_rate;
            tgt = round_sh((65536 - a) * y[act] + a * rew, 16);
            err = tgt - y[act];
            g = round_sh(err * y[act], 16);
            delta = round_sh(g * (65536 - y[act]), 16);
            ed = round_sh(eta * delta, 16);
            // Output layer first, then hidden layer with the new weights
            for (int j = 0; j < 2; j++)
                w_hid_out[j][act] = sat_weight(w_hid_out[j][act], round_sh(ed * hid[j], 16));
            w_hid_out[2][act] = sat_weight(w_hid_out[2][act], -ed);
            for (int i = 0; i < 2; i++) begin
                hh = round_sh(hid[i] * (65536 - hid[i]), 16);
                t1 = round_sh(hh * longint'(w_hid_out[i][act]), 16);
                tt = round_sh(t1 * delta, 16);
                et = round_sh(eta * tt, 16);
                w_in_hid[s][i] = sat_weight(w_in_hid[s][i], et);
                w_in_hid[2][i] = sat_weight(w_in_hid[2][i], -et);
            end
            env_state = act;
            owed_words.push_back({4'b0, rew[15:0], y[1][16:0], y[0][16:0],
                                  expl[0], act[0]});
        endfunction

        function void check_result(logic [55:0] got);
            logic [55:0] want;
            if (owed_words.size() == 0) begin
                $error("result word with nothing owed: %h", got);
                errors++;
                return;
            end
            want = owed_words.pop_front();
            if (got[0] !== want[0]) begin
                $error("chosen_action: expected %0d actual %0d", want[0], got[0]);
                errors++;
            end
            if (got[1] !== want[1]) begin
                $error("explored: expected %0d actual %0d", want[1], got[1]);
                errors++;
            end
            if (got[18:2] !== want[18:2]) begin
                $error("q_value_a0: expected %0d actual %0d", want[18:2], got[18:2]);
                errors++;
            end
            if (got[35:19] !== want[35:19]) begin
                $error("q_value_a1: expected %0d actual %0d", want[35:19], got[35:19]);
                errors++;
            end
            if (got[51:36] !== want[51:36]) begin
                $error("reward_given: expected %0d actual %0d", want[51:36], got[51:36]);
                errors++;
            end
            if (got[55:52] !== want[55:52]) begin
                $error("pad: expected %0d actual %0d", want[55:52], got[55:52]);
                errors++;
            end
        endfunction
    endclass

    qstep_scoreboard tracker = new();

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL mlp_q_learning_step_top");
            $finish;
        end
    end

    // Result side: stall at random, check each accepted word
    initial begin
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(99) >= recv_idle_pct);
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata);
        end
    end

    task automatic send_word(input logic [55:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = w;
        do @(posedge aclk); while (!s_tready);
        tracker.note_word(w);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] v);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        @(posedge aclk);
        tracker.write_reg(idx, v);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Hold until every owed word is back and the block has settled
    task automatic drain();
        while (tracker.owed_words.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [55:0] pack_word(logic [1:0] op, logic [3:0] widx,
                                              logic [31:0] wval, logic st,
                                              logic [15:0] draw, logic ract);
        return {ract, draw, st, wval, widx, op};
    endfunction

    function automatic logic [31:0] pick_weight();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return 32'($signed($urandom_range(2 * 786432)) - 786432);
        if (sel < 85) return $urandom;
        case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0008_0000;
            default: return 32'hFFF8_0000;
        endcase
    endfunction

    task automatic send_random(input int count);
        int sel;
        logic [1:0] op;
        logic [3:0] widx;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 50) op = mqls_pkg::OP_STEP;
            else if (sel < 75) op = mqls_pkg::OP_LOAD;
            else if (sel < 90) op = mqls_pkg::OP_STATE;
            else op = OP_NOP;
            widx = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 12))
                                            : 4'($urandom_range(11));
            send_word(pack_word(op, widx, pick_weight(), 1'($urandom),
                                16'($urandom), 1'($urandom)));
        end
    endtask

    task automatic write_random_regs();
        write_reg(mqls_pkg::CFG_EXPLORE, 20'($urandom_range(65535)));
        write_reg(mqls_pkg::CFG_Q_BLEND, 20'($urandom_range(65535)));
        write_reg(mqls_pkg::CFG_NET_LEARN, 20'($urandom_range(1048575)));
        write_reg(mqls_pkg::CFG_REWARD_S0A0, 20'($urandom_range(65535)));
        write_reg(mqls_pkg::CFG_REWARD_S0A1, 20'($urandom_range(65535)));
        write_reg(mqls_pkg::CFG_REWARD_S1A0, 20'($urandom_range(65535)));
        write_reg(mqls_pkg::CFG_REWARD_S1A1, 20'($urandom_range(65535)));
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: loads at the extremes, ignored slots, steps, state, no-op
        send_idle_pct = 22;
        recv_idle_pct = 47;
        send_word(pack_word(mqls_pkg::OP_STEP, 4'd0, 32'd0, 1'b0, 16'hFFFF, 1'b0));
        send_word(pack_word(mqls_pkg::OP_STEP, 4'd0, 32'd0, 1'b0, 16'h0000, 1'b1));
        for (int k = 0; k < 12; k++)
            send_word(pack_word(mqls_pkg::OP_LOAD, 4'(k),
                                (k % 2) ? 32'h0002_0000 : 32'hFFFF_0000,
                                1'b0, 16'd0, 1'b0));
        send_word(pack_word(mqls_pkg::OP_LOAD, 4'd15, 32'h7FFF_FFFF, 1'b1, 16'hFFFF, 1'b1));
        send_word(pack_word(mqls_pkg::OP_STATE, 4'd0, 32'd0, 1'b1, 16'd0, 1'b0));
        send_word(pack_word(mqls_pkg::OP_STEP, 4'd0, 32'd0, 1'b0, 16'hFFFF, 1'b0));
        send_word(pack_word(OP_NOP, 4'hF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1));
        send_word(pack_word(mqls_pkg::OP_LOAD, 4'd0, 32'h7FFF_FFFF, 1'b0, 16'd0, 1'b0));
        send_word(pack_word(mqls_pkg::OP_LOAD, 4'd4, 32'h8000_0000, 1'b0, 16'd0, 1'b0));
        send_word(pack_word(mqls_pkg::OP_STATE, 4'd0, 32'd0, 1'b0, 16'd0, 1'b0));
        send_word(pack_word(mqls_pkg::OP_STEP, 4'd0, 32'd0, 1'b0, 16'h7FFF, 1'b1));
        send_word(pack_word(mqls_pkg::OP_STEP, 4'd0, 32'd0, 1'b0, 16'h8000, 1'b0));
        drain();

        // Extreme settings, including the unused register slot
        write_reg(mqls_pkg::CFG_EXPLORE, 20'd65535);
        write_reg(mqls_pkg::CFG_Q_BLEND, 20'd65535);
        write_reg(mqls_pkg::CFG_NET_LEARN, 20'hFFFFF);
        write_reg(mqls_pkg::CFG_REWARD_S0A0, 20'd0);
        write_reg(mqls_pkg::CFG_REWARD_S0A1, 20'd65535);
        write_reg(mqls_pkg::CFG_REWARD_S1A0, 20'd65535);
        write_reg(mqls_pkg::CFG_REWARD_S1A1, 20'd0);
        write_reg(CFG_SPARE, 20'hFFFFF);
        send_random(110);
        drain();
        write_reg(mqls_pkg::CFG_EXPLORE, 20'd0);
        write_reg(mqls_pkg::CFG_Q_BLEND, 20'd0);
        write_reg(mqls_pkg::CFG_NET_LEARN, 20'd0);
        send_random(110);
        drain();

        send_idle_pct = 47;
        recv_idle_pct = 22;
        write_random_regs();
        send_random(230);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_random_regs();
        send_random(240);
        drain();

        if (tracker.errors == 0) begin
            $display("PASS mlp_q_learning_step_top");
        end else begin
            $display("FAIL mlp_q_learning_step_top");
        end
        $finish;
    end

endmodule

`default_nettype wire
